[hdl/macx_pkg.sv]
// Shared types and constants for the moving average crossover detector.
package macx_pkg;

  // Field widths of the request and result items.
  localparam int PRICE_IN_W = 32;
  localparam int TIME_W     = 63;

  // Widths of the window length registers.
  localparam int FAST_W = 8;
  localparam int SLOW_W = 9;

  // Configuration port shape.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = SLOW_W;

  // Defaults for the top level parameters.
  localparam int DEF_MAX_WINDOW = 256;
  localparam int DEF_PRICE_BITS = 32;

  // Reset values of the window lengths.
  localparam logic [FAST_W-1:0] FAST_RESET = FAST_W'(1);
  localparam logic [SLOW_W-1:0] SLOW_RESET = SLOW_W'(2);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FAST_LENGTH = 1'b0,
    REG_SLOW_LENGTH = 1'b1
  } reg_index_t;

  // Sign of the fast average minus the slow average.
  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_ABOVE = 2'd1,
    SIGN_BELOW = 2'd2
  } sign_t;

  // Crossover direction codes.
  localparam logic DIR_SHORT = 1'b0;
  localparam logic DIR_LONG  = 1'b1;

  // One bar request.
  typedef struct packed {
    logic [PRICE_IN_W-1:0] close_price;
    logic [TIME_W-1:0]     bar_time;
  } bar_item_t;

  // One crossover result.
  typedef struct packed {
    logic [TIME_W-1:0] signal_time;
    logic              direction;
  } signal_item_t;

endpackage

[hdl/macx_stream_if.sv]
// Valid/ready channel that carries one payload per handshake.
interface macx_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/macx_ram.sv]
// Generic single-write, single-read RAM with a registered, read-first output.
module macx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/moving_average_crossover_detector.sv]
// Top level of the moving average crossover detector.
//
// Takes one bar request (close price and timestamp) per clock cycle and emits a
// result holding the bar's timestamp and direction whenever the sign of the fast
// average minus the slow average flips between above and below, once the slow
// window is full. Equal averages keep the previous sign. Averages are compared
// exactly as fast_total*slow_length against slow_total*fast_length. The block
// sustains one bar per cycle: both leaving prices are read at once from two
// copies of the price ring into the input register, and the sums, the cross
// products and the compare follow in one pass into the output register. The
// input register holds its bar while the skid register is full. Bars ready
// drops only while the skid register holds a second result that the consumer
// has not taken. With fast_length zero, slow_length zero, fast_length not
// below slow_length or slow_length above MAX_WINDOW, bars are accepted and
// ignored. Any register write restarts the stream.
// Write configuration only while no bar is in flight.
module moving_average_crossover_detector #(
  parameter int MAX_WINDOW = macx_pkg::DEF_MAX_WINDOW,
  parameter int PRICE_BITS = macx_pkg::DEF_PRICE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  macx_stream_if.sink                         bars,
  macx_stream_if.source                       signals,
  input  logic                                cfg_write,
  input  logic [macx_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [macx_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int OFS_W  = ADDR_W + 1;
  localparam int SUM_W  = PRICE_BITS + macx_pkg::SLOW_W;
  localparam int PROD_W = SUM_W + macx_pkg::SLOW_W;
  localparam int FAST_W = macx_pkg::FAST_W;
  localparam int SLOW_W = macx_pkg::SLOW_W;
  localparam int TIME_W = macx_pkg::TIME_W;

  // Configuration registers.
  logic [FAST_W-1:0] fast_length;
  logic [SLOW_W-1:0] slow_length;
  logic              cfg_ok;

  // Stream state.
  logic [ADDR_W-1:0] ring_head;
  logic [SLOW_W-1:0] fill_count;
  logic [SLOW_W-1:0] fill_next;
  logic [SUM_W-1:0]  fast_total;
  logic [SUM_W-1:0]  slow_total;
  macx_pkg::sign_t   last_sign;

  // Handshake and pipeline control.
  logic advance;
  logic accept;
  logic take;

  // Ring addressing.
  logic [OFS_W-1:0]      fast_back;
  logic [OFS_W-1:0]      slow_back;
  logic [ADDR_W-1:0]     fast_addr;
  logic [ADDR_W-1:0]     slow_addr;
  logic [PRICE_BITS-1:0] price;
  logic [PRICE_BITS-1:0] fast_old;
  logic [PRICE_BITS-1:0] slow_old;

  // Input register: price captured, ring reads in flight.
  logic                  s1_valid;
  logic [PRICE_BITS-1:0] s1_price;
  logic [TIME_W-1:0]     s1_time;
  logic                  s1_fast_sub;
  logic                  s1_slow_sub;
  logic                  s1_check;

  // Sums and cross products for the bar in the input register.
  logic [SUM_W-1:0]  fast_total_next;
  logic [SUM_W-1:0]  slow_total_next;
  logic [PROD_W-1:0] fast_prod;
  logic [PROD_W-1:0] slow_prod;

  // Compare and emit.
  macx_pkg::sign_t        sign;
  logic                   emit;
  macx_pkg::signal_item_t emit_item;

  // Output register and skid register.
  logic                   out_valid;
  macx_pkg::signal_item_t out_item;
  logic                   skid_valid;
  macx_pkg::signal_item_t skid_item;

  assign cfg_ok = (fast_length != '0) && (slow_length != '0) &&
                  ({1'b0, fast_length} < slow_length) &&
                  (32'(slow_length) <= 32'(MAX_WINDOW));

  // The pipeline moves whenever the skid register is free.
  assign advance    = !skid_valid;
  assign bars.ready = advance;
  assign accept     = bars.valid && bars.ready;
  assign take       = accept && cfg_ok;
  assign price      = PRICE_BITS'(bars.payload.close_price);

  // Slots written fast_length and slow_length bars ago.
  always_comb begin
    fast_back = OFS_W'(ring_head) + OFS_W'(MAX_WINDOW) - OFS_W'(fast_length);
    if (fast_back >= OFS_W'(MAX_WINDOW)) begin
      fast_back = fast_back - OFS_W'(MAX_WINDOW);
    end
    slow_back = OFS_W'(ring_head) + OFS_W'(MAX_WINDOW) - OFS_W'(slow_length);
    if (slow_back >= OFS_W'(MAX_WINDOW)) begin
      slow_back = slow_back - OFS_W'(MAX_WINDOW);
    end
    fast_addr = fast_back[ADDR_W-1:0];
    slow_addr = slow_back[ADDR_W-1:0];
  end

  assign fill_next = (fill_count < slow_length) ? fill_count + SLOW_W'(1) : fill_count;

  // Two copies of the ring give two read ports; both take every write.
  macx_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_fast_ring (
    .clk   (clk),
    .we    (take),
    .waddr (ring_head),
    .wdata (price),
    .re    (take),
    .raddr (fast_addr),
    .rdata (fast_old)
  );

  macx_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_slow_ring (
    .clk   (clk),
    .we    (take),
    .waddr (ring_head),
    .wdata (price),
    .re    (take),
    .raddr (slow_addr),
    .rdata (slow_old)
  );

  // Configuration writes; any write restarts the stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_length <= macx_pkg::FAST_RESET;
      slow_length <= macx_pkg::SLOW_RESET;
    end else if (cfg_write) begin
      unique case (macx_pkg::reg_index_t'(cfg_index))
        macx_pkg::REG_FAST_LENGTH: fast_length <= cfg_data[FAST_W-1:0];
        macx_pkg::REG_SLOW_LENGTH: slow_length <= cfg_data[SLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring head and fill count move when a bar is taken.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      ring_head  <= '0;
      fill_count <= '0;
    end else if (take) begin
      ring_head  <= (ring_head == ADDR_W'(MAX_WINDOW - 1)) ? '0 : ring_head + ADDR_W'(1);
      fill_count <= fill_next;
    end
  end

  // Input register capture.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_price    <= price;
      s1_time     <= bars.payload.bar_time;
      s1_fast_sub <= (fill_count >= {1'b0, fast_length});
      s1_slow_sub <= (fill_count >= slow_length);
      s1_check    <= (fill_next >= slow_length);
    end
  end

  // Running sums drop the leaving prices and add the new one; cross products
  // replace the division of both averages.
  always_comb begin
    fast_total_next = fast_total - (s1_fast_sub ? SUM_W'(fast_old) : '0) + SUM_W'(s1_price);
    slow_total_next = slow_total - (s1_slow_sub ? SUM_W'(slow_old) : '0) + SUM_W'(s1_price);
    fast_prod       = PROD_W'(fast_total_next) * PROD_W'(slow_length);
    slow_prod       = PROD_W'(slow_total_next) * PROD_W'(fast_length);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      fast_total <= '0;
      slow_total <= '0;
    end else if (advance && s1_valid) begin
      fast_total <= fast_total_next;
      slow_total <= slow_total_next;
    end
  end

  // Compare the products and detect a flip of the remembered sign.
  always_comb begin
    if (fast_prod > slow_prod) begin
      sign = macx_pkg::SIGN_ABOVE;
    end else if (fast_prod < slow_prod) begin
      sign = macx_pkg::SIGN_BELOW;
    end else begin
      sign = macx_pkg::SIGN_NONE;
    end
    emit = s1_valid && s1_check && (sign != macx_pkg::SIGN_NONE) &&
           (last_sign != macx_pkg::SIGN_NONE) && (sign != last_sign);
    emit_item.signal_time = s1_time;
    emit_item.direction   = (sign == macx_pkg::SIGN_ABOVE) ? macx_pkg::DIR_LONG
                                                           : macx_pkg::DIR_SHORT;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      last_sign <= macx_pkg::SIGN_NONE;
    end else if (advance && s1_valid && s1_check && sign != macx_pkg::SIGN_NONE) begin
      last_sign <= sign;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (signals.ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !signals.ready) begin
      skid_valid <= emit;
    end else begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (signals.ready) begin
        out_item <= skid_item;
      end
    end else if (out_valid && !signals.ready) begin
      if (emit) begin
        skid_item <= emit_item;
      end
    end else if (emit) begin
      out_item <= emit_item;
    end
  end

  assign signals.valid   = out_valid;
  assign signals.payload = out_item;

endmodule
